// ----- rtl/sdsc_pkg.sv -----
// Shared constants and types for the SMTP DATA dot-stuffing / CR LF shaper.
package sdsc_pkg;

  // Characters the shaper inspects or inserts
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Most bytes a single transaction can produce; extras are dropped
  localparam int EMIT_MAX = 12;
  localparam int CNT_W    = 4;

  // Trailer storage: the register always holds eight bytes
  localparam int DELIM_DEFAULT_BYTES = 8;
  localparam int DELIM_REG_W         = 64;
  localparam int DELIM_IDX_W         = 3;
  localparam int DELIM_LEN_W         = 4;

  // Configuration bus
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_FIX_NEWLINES  = 2'd0;
  localparam logic [1:0] REG_FIX_DOTS      = 2'd1;
  localparam logic [1:0] REG_DELIM_BYTES   = 2'd2;
  localparam logic [1:0] REG_DELIM_LENGTH  = 2'd3;

  typedef struct packed {
    logic                   fix_newlines;
    logic                   fix_dots;
    logic [DELIM_REG_W-1:0] delimiter_bytes;
    logic [DELIM_LEN_W-1:0] delimiter_length;
  } cfg_t;

  typedef logic [EMIT_MAX-1:0][7:0] emit_bytes_t;

endpackage

// ----- rtl/sdsc_if.sv -----
// Valid/ready channel interfaces for the shaper's input and result streams.
interface sdsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sdsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_done;

  modport source (output valid, out_byte, run_last, message_done, input ready);
  modport sink   (input valid, out_byte, run_last, message_done, output ready);
endinterface

// ----- rtl/sdsc_expand.sv -----
// Expands one input transaction into its ordered output bytes and next line state.
module sdsc_expand #(
  parameter int DELIM_MAX_BYTES = sdsc_pkg::DELIM_DEFAULT_BYTES
) (
  input  sdsc_pkg::cfg_t                 cfg,
  input  logic [7:0]                     data_byte,
  input  logic                           byte_present,
  input  logic                           message_end,
  input  logic                           at_line_start,
  input  logic                           cr_pending,
  output sdsc_pkg::emit_bytes_t          emit_bytes,
  output logic [sdsc_pkg::CNT_W-1:0]     emit_count,
  output logic                           at_line_start_nxt,
  output logic                           cr_pending_nxt
);

  localparam int CW = sdsc_pkg::CNT_W;
  localparam logic [CW-1:0] DelimMax = CW'(DELIM_MAX_BYTES);
  localparam logic [CW-1:0] EmitMax  = CW'(sdsc_pkg::EMIT_MAX);

  logic [3:0][7:0]  head;
  logic [1:0]       head_cnt;
  logic             als_a;
  logic             crp_a;
  logic [1:0]       end_cnt;
  logic [CW-1:0]    delim_cnt;
  logic [CW-1:0]    total;

  // Bytes caused by the message byte itself (held CR release, dot, body)
  always_comb begin
    head     = '0;
    head_cnt = '0;
    als_a    = at_line_start;
    crp_a    = cr_pending;
    if (byte_present) begin
      if (cr_pending) begin
        crp_a          = 1'b0;
        head[head_cnt] = sdsc_pkg::CH_CR;
        head_cnt       = head_cnt + 2'd1;
      end
      if (cr_pending && (data_byte == sdsc_pkg::CH_LF)) begin
        head[head_cnt] = sdsc_pkg::CH_LF;
        head_cnt       = head_cnt + 2'd1;
        als_a          = 1'b1;
      end else begin
        if (cfg.fix_dots && at_line_start && (data_byte == sdsc_pkg::CH_DOT)) begin
          head[head_cnt] = sdsc_pkg::CH_DOT;
          head_cnt       = head_cnt + 2'd1;
        end
        if (data_byte == sdsc_pkg::CH_LF) begin
          if (cfg.fix_newlines) begin
            head[head_cnt] = sdsc_pkg::CH_CR;
            head_cnt       = head_cnt + 2'd1;
          end
          head[head_cnt] = sdsc_pkg::CH_LF;
          head_cnt       = head_cnt + 2'd1;
          als_a          = 1'b1;
        end else begin
          als_a = 1'b0;
          if ((data_byte == sdsc_pkg::CH_CR) && cfg.fix_newlines) begin
            crp_a = 1'b1;
          end else begin
            head[head_cnt] = data_byte;
            head_cnt       = head_cnt + 2'd1;
          end
        end
      end
    end
  end

  // Message close: line terminator then the saturated trailer
  always_comb begin
    end_cnt   = 2'd0;
    delim_cnt = '0;
    if (message_end) begin
      if (crp_a || (cfg.fix_newlines && !als_a)) begin
        end_cnt = 2'd2;
      end
      delim_cnt = (cfg.delimiter_length > DelimMax) ? DelimMax : cfg.delimiter_length;
    end
  end

  assign total      = CW'(head_cnt) + CW'(end_cnt) + delim_cnt;
  assign emit_count = (total > EmitMax) ? EmitMax : total;

  assign at_line_start_nxt = message_end ? 1'b1 : als_a;
  assign cr_pending_nxt    = message_end ? 1'b0 : crp_a;

  // Each output slot picks from head, terminator or trailer on its own
  for (genvar k = 0; k < sdsc_pkg::EMIT_MAX; k++) begin : g_slot
    logic [CW-1:0] tail_pos;
    logic [CW-1:0] dly_pos;
    assign tail_pos = CW'(k) - CW'(head_cnt);
    assign dly_pos  = tail_pos - CW'(end_cnt);
    always_comb begin
      if (CW'(k) < CW'(head_cnt)) begin
        emit_bytes[k] = head[k % 4];
      end else if (tail_pos < CW'(end_cnt)) begin
        emit_bytes[k] = (tail_pos == '0) ? sdsc_pkg::CH_CR : sdsc_pkg::CH_LF;
      end else begin
        emit_bytes[k] = cfg.delimiter_bytes[dly_pos[sdsc_pkg::DELIM_IDX_W-1:0] * 8 +: 8];
      end
    end
  end

endmodule

// ----- rtl/smtp_data_dot_stuff_crlf.sv -----
// SMTP DATA shaper: dot stuffing, CR LF repair and trailer append.
// An accepted input transaction waits in the input register, then loads the
//   output buffer once the buffer is empty or its last byte is being taken.
// Throughput: one input per cycle while each input yields at most one byte
//   and the receiver is ready; larger inputs hold the buffer until drained.
// The shift buffer (one byte per ready cycle) sets the sustained rate.
// Reset (rst_n low, synchronous): buffers empty, line state at message
//   start, registers fix_newlines=1, fix_dots=1, delimiter cleared.
module smtp_data_dot_stuff_crlf #(
  parameter int DELIM_MAX_BYTES = sdsc_pkg::DELIM_DEFAULT_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sdsc_in_if.sink                         in_ch,
  sdsc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdsc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sdsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sdsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CW = sdsc_pkg::CNT_W;
  localparam int EM = sdsc_pkg::EMIT_MAX;

  // Configuration registers
  sdsc_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fix_newlines     <= 1'b1;
      cfg_r.fix_dots         <= 1'b1;
      cfg_r.delimiter_bytes  <= '0;
      cfg_r.delimiter_length <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sdsc_pkg::REG_FIX_NEWLINES: cfg_r.fix_newlines     <= pwdata[0];
        sdsc_pkg::REG_FIX_DOTS:     cfg_r.fix_dots         <= pwdata[0];
        sdsc_pkg::REG_DELIM_BYTES:  cfg_r.delimiter_bytes  <= pwdata;
        sdsc_pkg::REG_DELIM_LENGTH:
          cfg_r.delimiter_length <= pwdata[sdsc_pkg::DELIM_LEN_W-1:0];
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      sdsc_pkg::REG_FIX_NEWLINES: prdata = sdsc_pkg::APB_DATA_W'(cfg_r.fix_newlines);
      sdsc_pkg::REG_FIX_DOTS:     prdata = sdsc_pkg::APB_DATA_W'(cfg_r.fix_dots);
      sdsc_pkg::REG_DELIM_BYTES:  prdata = cfg_r.delimiter_bytes;
      sdsc_pkg::REG_DELIM_LENGTH: prdata = sdsc_pkg::APB_DATA_W'(cfg_r.delimiter_length);
    endcase
  end

  // Input register
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_pres_r;
  logic       in_end_r;
  logic       in_take;
  logic       advance;

  // Output shift buffer
  sdsc_pkg::emit_bytes_t buf_bytes_r, buf_bytes_nxt;
  logic [CW-1:0]         buf_left_r, buf_left_nxt;
  logic                  buf_end_r;
  logic                  pop;

  // Line state
  logic at_line_start_r, at_line_start_nxt;
  logic cr_pending_r, cr_pending_nxt;

  sdsc_pkg::emit_bytes_t exp_bytes;
  logic [CW-1:0]         exp_count;

  assign pop     = (buf_left_r != '0) && out_ch.ready;
  assign advance = in_v_r && ((buf_left_r == '0) || (out_ch.ready && (buf_left_r == CW'(1))));
  assign in_ch.ready = !in_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.data_byte;
      in_pres_r <= in_ch.byte_present;
      in_end_r  <= in_ch.message_end;
    end
  end

  sdsc_expand #(
    .DELIM_MAX_BYTES (DELIM_MAX_BYTES)
  ) u_expand (
    .cfg               (cfg_r),
    .data_byte         (in_byte_r),
    .byte_present      (in_pres_r),
    .message_end       (in_end_r),
    .at_line_start     (at_line_start_r),
    .cr_pending        (cr_pending_r),
    .emit_bytes        (exp_bytes),
    .emit_count        (exp_count),
    .at_line_start_nxt (at_line_start_nxt),
    .cr_pending_nxt    (cr_pending_nxt)
  );

  // Line state moves on when a transaction is expanded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      cr_pending_r    <= 1'b0;
    end else if (advance) begin
      at_line_start_r <= at_line_start_nxt;
      cr_pending_r    <= cr_pending_nxt;
    end
  end

  // Load on advance, otherwise shift one byte out per pop
  always_comb begin
    buf_bytes_nxt = buf_bytes_r;
    buf_left_nxt  = buf_left_r;
    if (advance) begin
      buf_bytes_nxt = exp_bytes;
      buf_left_nxt  = exp_count;
    end else if (pop) begin
      for (int i = 0; i < EM - 1; i++) begin
        buf_bytes_nxt[i] = buf_bytes_r[i+1];
      end
      buf_bytes_nxt[EM-1] = 8'h00;
      buf_left_nxt        = buf_left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_left_r <= '0;
    end else begin
      buf_left_r <= buf_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_bytes_r <= buf_bytes_nxt;
    if (advance) begin
      buf_end_r <= in_end_r;
    end
  end

  assign out_ch.valid        = (buf_left_r != '0);
  assign out_ch.out_byte     = buf_bytes_r[0];
  assign out_ch.run_last     = (buf_left_r == CW'(1));
  assign out_ch.message_done = (buf_left_r == CW'(1)) && buf_end_r;

endmodule

// ----- rtl/sdsc_checker.sv -----
// Port-level checks for the shaper, bound onto the top level.
module sdsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       message_done
);

  // Message close only ever marks the last byte of a transaction
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_done |-> run_last)
    else $error("message_done without run_last");

  // Input only stalls when results are backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // Output starts only from an input transaction accepted earlier
  a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a source transaction");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled result changed");

endmodule

bind smtp_data_dot_stuff_crlf sdsc_checker u_sdsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .run_last     (out_ch.run_last),
  .message_done (out_ch.message_done)
);

// ----- verif/smtp_data_dot_stuff_crlf_chk.sv -----
// Checker for the SMTP DATA shaper: predicts the byte stream and compares each result.
module smtp_data_dot_stuff_crlf_chk (
  input  logic                            clk,
  input  logic                            rst_n,
  sdsc_in_if                              in_mon,
  sdsc_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [sdsc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sdsc_pkg::APB_DATA_W-1:0] pwdata,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_done;
  } shaped_byte_t;

  // Shadow copy of the registers
  logic                             nl_fix;
  logic                             dot_fix;
  logic [sdsc_pkg::DELIM_REG_W-1:0] trailer_bytes;
  logic [sdsc_pkg::DELIM_LEN_W-1:0] trailer_len;

  // Line state of the predictor
  logic line_start;
  logic cr_held;

  logic [7:0]   item_bytes[$];
  shaped_byte_t expected_stream[$];
  shaped_byte_t want;

  // Bytes beyond the per-transaction maximum are dropped
  function automatic void emit_byte(input logic [7:0] b);
    if (item_bytes.size() < sdsc_pkg::EMIT_MAX)
      item_bytes.push_back(b);
  endfunction

  // One message byte: release a held CR, stuff a leading dot, repair LF
  function automatic void stuff_byte(input logic [7:0] b);
    if (cr_held) begin
      cr_held = 1'b0;
      emit_byte(sdsc_pkg::CH_CR);
      if (b == sdsc_pkg::CH_LF) begin
        emit_byte(sdsc_pkg::CH_LF);
        line_start = 1'b1;
        return;
      end
    end
    if (dot_fix && line_start && b == sdsc_pkg::CH_DOT)
      emit_byte(sdsc_pkg::CH_DOT);
    if (b == sdsc_pkg::CH_LF) begin
      if (nl_fix)
        emit_byte(sdsc_pkg::CH_CR);
      emit_byte(sdsc_pkg::CH_LF);
      line_start = 1'b1;
      return;
    end
    line_start = 1'b0;
    if (b == sdsc_pkg::CH_CR && nl_fix) begin
      cr_held = 1'b1;
      return;
    end
    emit_byte(b);
  endfunction

  // Message end: terminate the open line, then append the trailer
  function automatic void close_message();
    int n;
    if (cr_held) begin
      emit_byte(sdsc_pkg::CH_CR);
      emit_byte(sdsc_pkg::CH_LF);
    end else if (nl_fix && !line_start) begin
      emit_byte(sdsc_pkg::CH_CR);
      emit_byte(sdsc_pkg::CH_LF);
    end
    n = (trailer_len > sdsc_pkg::DELIM_DEFAULT_BYTES) ? sdsc_pkg::DELIM_DEFAULT_BYTES
                                                       : int'(trailer_len);
    for (int i = 0; i < n; i++)
      emit_byte(trailer_bytes[8*i +: 8]);
    line_start = 1'b1;
    cr_held    = 1'b0;
  endfunction

  function automatic void predict_transaction(input logic [7:0] b, input logic present,
                                              input logic closes);
    shaped_byte_t s;
    item_bytes.delete();
    if (present)
      stuff_byte(b);
    if (closes)
      close_message();
    foreach (item_bytes[i]) begin
      s.out_byte     = item_bytes[i];
      s.run_last     = (i == item_bytes.size() - 1);
      s.message_done = s.run_last && closes;
      expected_stream.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      nl_fix        = 1'b1;
      dot_fix       = 1'b1;
      trailer_bytes = '0;
      trailer_len   = '0;
      line_start    = 1'b1;
      cr_held       = 1'b0;
      expected_stream.delete();
      mismatches    = 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[sdsc_pkg::APB_ADDR_W-1:3])
          sdsc_pkg::REG_FIX_NEWLINES: nl_fix        = pwdata[0];
          sdsc_pkg::REG_FIX_DOTS:     dot_fix       = pwdata[0];
          sdsc_pkg::REG_DELIM_BYTES:  trailer_bytes = pwdata[sdsc_pkg::DELIM_REG_W-1:0];
          sdsc_pkg::REG_DELIM_LENGTH: trailer_len   = pwdata[sdsc_pkg::DELIM_LEN_W-1:0];
          default: ;
        endcase
      end

      // Accepted input transaction
      if (in_mon.valid && in_mon.ready)
        predict_transaction(in_mon.data_byte, in_mon.byte_present, in_mon.message_end);

      // Accepted result transaction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_stream.size() == 0) begin
          $error("unexpected result: out_byte %h run_last %b message_done %b",
                 out_mon.out_byte, out_mon.run_last, out_mon.message_done);
          mismatches++;
        end else begin
          want = expected_stream.pop_front();
          if (out_mon.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, out_mon.out_byte);
            mismatches++;
          end
          if (out_mon.run_last !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, out_mon.run_last);
            mismatches++;
          end
          if (out_mon.message_done !== want.message_done) begin
            $error("message_done: expected %b, actual %b",
                   want.message_done, out_mon.message_done);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_stream.size();
  end

endmodule

// ----- verif/smtp_data_dot_stuff_crlf_tb.sv -----
// Testbench top for the SMTP DATA shaper: clock, reset, register set-up, stimulus, verdict.
module smtp_data_dot_stuff_crlf_tb;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TICK} rx_mode_t;

  localparam int DIRECTED_ITEMS = 25;
  localparam int RANDOM_ITEMS   = 180;
  localparam int HOLD_CYCLES    = 90;

  logic                            clk;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [sdsc_pkg::APB_ADDR_W-1:0] paddr;
  logic [sdsc_pkg::APB_DATA_W-1:0] pwdata;
  logic [sdsc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  int                              mismatches;
  int                              outstanding;
  int                              items_sent = 0;
  int                              burst_left = 0;
  bit                              hold_req   = 1'b0;

  sdsc_in_if  in_ch();
  sdsc_out_if out_ch();

  smtp_data_dot_stuff_crlf dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  smtp_data_dot_stuff_crlf_chk checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Run limit
  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

  // Receiver: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    out_ch.ready = 1'b0;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ((mode_left % 3) != 0);
        endcase
      end
    end
  end

  // Offer one input transaction; called and returns at a falling edge
  task automatic send_item(input logic [7:0] b, input logic present, input logic closes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.byte_present <= present;
    in_ch.message_end  <= closes;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (present || closes)
      items_sent++;
  endtask

  // Stop offering and wait until every expected byte has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [sdsc_pkg::APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic nl, input logic dots, input logic [63:0] trailer,
                           input logic [3:0] trailer_len);
    write_reg(sdsc_pkg::REG_FIX_NEWLINES, sdsc_pkg::APB_DATA_W'(nl));
    write_reg(sdsc_pkg::REG_FIX_DOTS, sdsc_pkg::APB_DATA_W'(dots));
    write_reg(sdsc_pkg::REG_DELIM_BYTES, sdsc_pkg::APB_DATA_W'(trailer));
    write_reg(sdsc_pkg::REG_DELIM_LENGTH, sdsc_pkg::APB_DATA_W'(trailer_len));
  endtask

  initial begin : stimulus
    int          phase;
    int          msgs;
    int          msg_len;
    logic [7:0]  b;
    logic [63:0] trailer;
    logic [3:0]  trailer_len;

    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.message_end  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ".\r\n" trailer, both repairs on
    configure(1'b1, 1'b1, 64'h0A_0D_2E, 4'd3);
    send_item(sdsc_pkg::CH_DOT, 1'b1, 1'b0);   // leading dot doubled
    send_item("a", 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_CR, 1'b1, 1'b0);    // CR LF pair
    send_item(sdsc_pkg::CH_LF, 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_CR, 1'b1, 1'b0);    // CR inside a line
    send_item("x", 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_LF, 1'b1, 1'b0);    // bare LF
    send_item(sdsc_pkg::CH_DOT, 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_DOT, 1'b1, 1'b0);   // second dot is not at line start
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);              // empty transaction
    send_item(sdsc_pkg::CH_LF, 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_CR, 1'b1, 1'b0);    // trailing lone CR
    send_item(8'hA5, 1'b0, 1'b1);
    send_item("a", 1'b1, 1'b0);                // unterminated last line
    send_item("c", 1'b1, 1'b1);
    drain();

    // Directed: full eight-byte trailer, most bytes per transaction
    configure(1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_item(sdsc_pkg::CH_DOT, 1'b1, 1'b1);
    send_item(sdsc_pkg::CH_LF, 1'b1, 1'b1);
    drain();

    // Directed: oversized trailer length saturates, zero bytes still sent
    configure(1'b1, 1'b1, 64'h0, 4'd15);
    send_item(sdsc_pkg::CH_CR, 1'b1, 1'b1);
    drain();

    // Directed: repairs off, no trailer, silent message ends
    configure(1'b0, 1'b0, 64'h0, 4'd0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(sdsc_pkg::CH_DOT, 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_CR, 1'b1, 1'b0);
    send_item(sdsc_pkg::CH_LF, 1'b1, 1'b0);
    send_item("z", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // Random phases of whole messages under random settings
    phase = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 3))
        0:       trailer = 64'h0;
        1:       trailer = 64'hFFFF_FFFF_FFFF_FFFF;
        default: trailer = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 4))
        0:       trailer_len = 4'd0;
        1:       trailer_len = 4'd8;
        2:       trailer_len = 4'd15;
        default: trailer_len = 4'($urandom_range(0, 15));
      endcase
      configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), trailer, trailer_len);

      // Long receiver hold-off while the sender keeps pushing
      if (phase == 2) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end

      msgs = $urandom_range(1, 4);
      for (int m = 0; m < msgs; m++) begin
        msg_len = (phase == 2 && m == 0) ? 30 : $urandom_range(0, 10);
        for (int k = 0; k < msg_len; k++) begin
          case ($urandom_range(0, 9))
            0, 1:    b = sdsc_pkg::CH_DOT;
            2, 3:    b = sdsc_pkg::CH_LF;
            4, 5:    b = sdsc_pkg::CH_CR;
            default: b = 8'($urandom_range(0, 255));
          endcase
          if ($urandom_range(0, 11) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
          send_item(b, 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        if ($urandom_range(0, 4) == 0)
          drain();
      end
      phase++;
    end

    // Wind down
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 20000 && outstanding != 0; i++) @(negedge clk);
    repeat (16) @(negedge clk);
    if (outstanding != 0)
      $error("%0d expected bytes never came out", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sdsc_pkg.sv
rtl/sdsc_if.sv
rtl/sdsc_expand.sv
rtl/smtp_data_dot_stuff_crlf.sv
rtl/sdsc_checker.sv
verif/smtp_data_dot_stuff_crlf_chk.sv
verif/smtp_data_dot_stuff_crlf_tb.sv
